// ===== sv/i2c_master_register_access_unit_assert.svh =====
// Assertion macros shared by the I2C register access unit RTL.
// Depends on nothing; include by bare file name inside a module body.
`ifndef I2C_MASTER_REGISTER_ACCESS_UNIT_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define I2CRA_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("i2cra assertion failed");

// Next-cycle implication, disabled during reset
`define I2CRA_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("i2cra assertion failed");

`endif

// ===== sv/i2cra_pkg.sv =====
// Types and constants for the I2C master register access unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2cra_pkg;

    // Largest number of data bytes per transaction
    localparam int unsigned MAX_BYTES = 256;
    localparam logic [8:0]  MAX_BYTES_W = 9'(MAX_BYTES);

    // Stream beat widths
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 24;

    // Command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HIGH_TICKS = 2'd0;
    localparam logic [1:0] CFG_SETUP_TICKS = 2'd1;
    localparam logic [1:0] CFG_LOW_TAIL_TICKS = 2'd2;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST_A     = 4'd1,
        PH_ST_B     = 4'd2,
        PH_TX_SETUP = 4'd3,
        PH_TX_HIGH  = 4'd4,
        PH_TX_LOW   = 4'd5,
        PH_ACK_REL  = 4'd6,
        PH_ACK_POLL = 4'd7,
        PH_ACK_HOLD = 4'd8,
        PH_RX_LOW   = 4'd9,
        PH_RX_HIGH  = 4'd10,
        PH_RA_LOW   = 4'd11,
        PH_RA_HIGH  = 4'd12,
        PH_SP_A     = 4'd13,
        PH_SP_B     = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        SG_DEV   = 2'd0,
        SG_REG   = 2'd1,
        SG_DEVRD = 2'd2,
        SG_DATA  = 2'd3
    } stage_t;

    typedef struct packed {
        logic [9:0] high_ticks;
        logic [9:0] setup_ticks;
        logic [9:0] low_tail_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [9:0] tick_count;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic [8:0] bytes_left;
        logic [7:0] ack_wait;
        logic [7:0] latched_dev;
        logic [7:0] latched_reg;
        logic       is_read;
        logic       scl;
        logic       sda;
        stage_t     stage;
        logic [8:0] data_index;
        logic       failed;
    } seq_t;

    // Sequencer state after reset: idle, bus released
    localparam seq_t SEQ_RESET = '{
        phase:       PH_IDLE,
        tick_count:  10'd0,
        bit_count:   4'd0,
        shift_byte:  8'd0,
        bytes_left:  9'd0,
        ack_wait:    8'd0,
        latched_dev: 8'd0,
        latched_reg: 8'd0,
        is_read:     1'b0,
        scl:         1'b1,
        sda:         1'b0,
        stage:       SG_DEV,
        data_index:  9'd0,
        failed:      1'b0
    };

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [8:0] byte_count;
        logic [7:0] wr_byte;
        logic       sda_sample;
    } tick_in_t;

    typedef struct packed {
        logic       ok;
        logic       done_res;
        logic [7:0] byte_index;
        logic       wr_take;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_level;
    } tick_out_t;

endpackage

`default_nettype wire

// ===== sv/i2cra_cfg.sv =====
// Configuration register file of the I2C register access unit.
// Depends on i2cra_pkg.
`default_nettype none

module i2cra_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    output i2cra_pkg::cfg_t  cfg
);
    import i2cra_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_ticks     <= 10'd13;
            cfg_reg.setup_ticks    <= 10'd5;
            cfg_reg.low_tail_ticks <= 10'd8;
            cfg_reg.ack_timeout    <= 8'd50;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIGH_TICKS:     cfg_reg.high_ticks     <= cfg_data;
                CFG_SETUP_TICKS:    cfg_reg.setup_ticks    <= cfg_data;
                CFG_LOW_TAIL_TICKS: cfg_reg.low_tail_ticks <= cfg_data;
                CFG_ACK_TIMEOUT:    cfg_reg.ack_timeout    <= cfg_data[7:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/i2cra_step.sv =====
// One-tick sequencer step: next bus state and result fields for one tick.
// Depends on i2cra_pkg; purely combinational.
`default_nettype none

module i2cra_step (
    input  i2cra_pkg::seq_t      st,
    input  i2cra_pkg::tick_in_t  tin,
    input  i2cra_pkg::cfg_t      cfg,
    output i2cra_pkg::seq_t      nxt,
    output i2cra_pkg::tick_out_t res
);
    import i2cra_pkg::*;

    logic [8:0] bl_dec;
    logic [8:0] idx_inc;
    logic [8:0] n_sat;
    logic [7:0] sh_tx;
    logic [7:0] sh_rx;
    logic [3:0] bc_inc;

    assign bl_dec  = (st.bytes_left != 9'd0) ? (st.bytes_left - 9'd1) : 9'd0;
    assign idx_inc = st.data_index + 9'd1;
    assign n_sat   = (tin.byte_count > MAX_BYTES_W) ? MAX_BYTES_W : tin.byte_count;
    assign sh_tx   = {st.shift_byte[6:0], 1'b0};
    assign sh_rx   = {st.shift_byte[6:0], tin.sda_sample};
    assign bc_inc  = st.bit_count + 4'd1;

    always_comb
    begin
        nxt = st;
        res = '0;

        if (st.phase == PH_IDLE)
        begin
            // Latch a new command and issue START
            if (tin.cmd == CMD_READ || tin.cmd == CMD_WRITE)
            begin
                nxt.latched_dev = tin.dev_addr;
                nxt.latched_reg = tin.reg_addr;
                nxt.is_read     = (tin.cmd == CMD_READ);
                nxt.bytes_left  = n_sat;
                nxt.data_index  = 9'd0;
                nxt.failed      = 1'b0;
                nxt.ack_wait    = 8'd0;
                nxt.stage       = SG_DEV;
                nxt.shift_byte  = tin.dev_addr;
                nxt.phase       = PH_ST_A;
                nxt.scl         = 1'b1;
                nxt.sda         = 1'b0;
                nxt.tick_count  = cfg.high_ticks;
            end
        end
        else if (st.phase == PH_ACK_POLL)
        begin
            // Poll for ACK with SCL high, abort with STOP on timeout
            if (!tin.sda_sample)
            begin
                nxt.phase      = PH_ACK_HOLD;
                nxt.scl        = 1'b1;
                nxt.sda        = 1'b0;
                nxt.tick_count = cfg.high_ticks;
            end
            else if (st.ack_wait >= cfg.ack_timeout)
            begin
                nxt.failed     = 1'b1;
                nxt.phase      = PH_SP_A;
                nxt.scl        = 1'b0;
                nxt.sda        = 1'b1;
                nxt.tick_count = cfg.high_ticks;
            end
            else
            begin
                nxt.ack_wait = st.ack_wait + 8'd1;
            end
        end
        else if (st.tick_count > 10'd1)
        begin
            nxt.tick_count = st.tick_count - 10'd1;
        end
        else
        begin
            // Segment over: advance to the next bus segment
            case (st.phase)
                PH_ST_A:
                begin
                    nxt.phase      = PH_ST_B;
                    nxt.scl        = 1'b1;
                    nxt.sda        = 1'b1;
                    nxt.tick_count = cfg.high_ticks;
                end
                PH_ST_B:
                begin
                    nxt.bit_count  = 4'd0;
                    nxt.phase      = PH_TX_SETUP;
                    nxt.scl        = 1'b0;
                    nxt.sda        = ~st.shift_byte[7];
                    nxt.tick_count = cfg.setup_ticks;
                end
                PH_TX_SETUP:
                begin
                    nxt.phase      = PH_TX_HIGH;
                    nxt.scl        = 1'b1;
                    nxt.tick_count = cfg.high_ticks;
                end
                PH_TX_HIGH:
                begin
                    nxt.phase      = PH_TX_LOW;
                    nxt.scl        = 1'b0;
                    nxt.tick_count = cfg.low_tail_ticks;
                end
                PH_TX_LOW:
                begin
                    nxt.shift_byte = sh_tx;
                    nxt.bit_count  = bc_inc;
                    nxt.scl        = 1'b0;
                    if (bc_inc >= 4'd8)
                    begin
                        nxt.ack_wait   = 8'd0;
                        nxt.phase      = PH_ACK_REL;
                        nxt.sda        = 1'b0;
                        nxt.tick_count = cfg.high_ticks;
                    end
                    else
                    begin
                        nxt.phase      = PH_TX_SETUP;
                        nxt.sda        = ~sh_tx[7];
                        nxt.tick_count = cfg.setup_ticks;
                    end
                end
                PH_ACK_REL:
                begin
                    nxt.phase      = PH_ACK_POLL;
                    nxt.scl        = 1'b1;
                    nxt.sda        = 1'b0;
                    nxt.tick_count = 10'd0;
                end
                PH_ACK_HOLD:
                begin
                    case (st.stage)
                        SG_DEV:
                        begin
                            nxt.shift_byte = st.latched_reg;
                            nxt.stage      = SG_REG;
                            nxt.bit_count  = 4'd0;
                            nxt.phase      = PH_TX_SETUP;
                            nxt.scl        = 1'b0;
                            nxt.sda        = ~st.latched_reg[7];
                            nxt.tick_count = cfg.setup_ticks;
                        end
                        SG_REG:
                        begin
                            if (st.is_read)
                            begin
                                // Repeated START toward the read address
                                nxt.stage      = SG_DEVRD;
                                nxt.shift_byte = st.latched_dev + 8'd1;
                                nxt.phase      = PH_ST_A;
                                nxt.scl        = 1'b1;
                                nxt.sda        = 1'b0;
                                nxt.tick_count = cfg.high_ticks;
                            end
                            else if (st.bytes_left == 9'd0)
                            begin
                                nxt.phase      = PH_SP_A;
                                nxt.scl        = 1'b0;
                                nxt.sda        = 1'b1;
                                nxt.tick_count = cfg.high_ticks;
                            end
                            else
                            begin
                                nxt.shift_byte = tin.wr_byte;
                                res.wr_take    = 1'b1;
                                nxt.stage      = SG_DATA;
                                nxt.bit_count  = 4'd0;
                                nxt.phase      = PH_TX_SETUP;
                                nxt.scl        = 1'b0;
                                nxt.sda        = ~tin.wr_byte[7];
                                nxt.tick_count = cfg.setup_ticks;
                            end
                        end
                        SG_DEVRD:
                        begin
                            if (st.bytes_left == 9'd0)
                            begin
                                nxt.phase      = PH_SP_A;
                                nxt.scl        = 1'b0;
                                nxt.sda        = 1'b1;
                                nxt.tick_count = cfg.high_ticks;
                            end
                            else
                            begin
                                nxt.bit_count  = 4'd0;
                                nxt.shift_byte = 8'd0;
                                nxt.phase      = PH_RX_LOW;
                                nxt.scl        = 1'b0;
                                nxt.sda        = 1'b0;
                                nxt.tick_count = cfg.high_ticks;
                            end
                        end
                        default:
                        begin
                            // Data byte acknowledged: count it, fetch the next one or STOP when none is left
                            nxt.bytes_left = bl_dec;
                            nxt.data_index = idx_inc;
                            if (bl_dec == 9'd0)
                            begin
                                nxt.phase      = PH_SP_A;
                                nxt.scl        = 1'b0;
                                nxt.sda        = 1'b1;
                                nxt.tick_count = cfg.high_ticks;
                            end
                            else
                            begin
                                nxt.shift_byte = tin.wr_byte;
                                res.wr_take    = 1'b1;
                                nxt.stage      = SG_DATA;
                                nxt.bit_count  = 4'd0;
                                nxt.phase      = PH_TX_SETUP;
                                nxt.scl        = 1'b0;
                                nxt.sda        = ~tin.wr_byte[7];
                                nxt.tick_count = cfg.setup_ticks;
                            end
                        end
                    endcase
                end
                PH_RX_LOW:
                begin
                    nxt.shift_byte = sh_rx;
                    nxt.phase      = PH_RX_HIGH;
                    nxt.scl        = 1'b1;
                    nxt.sda        = 1'b0;
                    nxt.tick_count = cfg.high_ticks;
                end
                PH_RX_HIGH:
                begin
                    nxt.bit_count  = bc_inc;
                    nxt.scl        = 1'b0;
                    nxt.tick_count = cfg.high_ticks;
                    if (bc_inc >= 4'd8)
                    begin
                        res.rd_byte  = st.shift_byte;
                        res.rd_valid = 1'b1;
                        nxt.phase    = PH_RA_LOW;
                        nxt.sda      = (st.bytes_left > 9'd1);
                    end
                    else
                    begin
                        nxt.phase = PH_RX_LOW;
                        nxt.sda   = 1'b0;
                    end
                end
                PH_RA_LOW:
                begin
                    nxt.phase      = PH_RA_HIGH;
                    nxt.scl        = 1'b1;
                    nxt.tick_count = cfg.high_ticks;
                end
                PH_RA_HIGH:
                begin
                    nxt.bytes_left = bl_dec;
                    nxt.data_index = idx_inc;
                    nxt.scl        = 1'b0;
                    nxt.tick_count = cfg.high_ticks;
                    if (bl_dec == 9'd0)
                    begin
                        nxt.phase = PH_SP_A;
                        nxt.sda   = 1'b1;
                    end
                    else
                    begin
                        nxt.bit_count  = 4'd0;
                        nxt.shift_byte = 8'd0;
                        nxt.phase      = PH_RX_LOW;
                        nxt.sda        = 1'b0;
                    end
                end
                PH_SP_A:
                begin
                    nxt.phase      = PH_SP_B;
                    nxt.scl        = 1'b1;
                    nxt.sda        = 1'b0;
                    nxt.tick_count = cfg.high_ticks;
                end
                default:
                begin
                    // STOP complete: release the bus and report status
                    nxt.phase      = PH_IDLE;
                    nxt.scl        = 1'b1;
                    nxt.sda        = 1'b0;
                    nxt.tick_count = 10'd0;
                    res.done_res   = 1'b1;
                    res.ok         = ~st.failed;
                end
            endcase
        end

        // Line levels and status after this tick
        res.scl_level    = nxt.scl;
        res.sda_pull_low = nxt.sda;
        res.busy_res     = (nxt.phase != PH_IDLE);
        res.byte_index   = (nxt.phase != PH_IDLE) ? nxt.data_index[7:0] : 8'd0;
    end

endmodule

`default_nettype wire

// ===== sv/i2c_master_register_access_unit.sv =====
// Top level of the I2C master register access unit: stream ports, sequencer
// state, result register. Depends on i2cra_pkg, i2cra_cfg, i2cra_step and the
// assertion macro header.
//
// Usage: every input beat on s_axis is one timing tick of the bit-banged bus.
// It carries the sampled SDA level and, while the unit is idle, a command in
// tuser (read or write of byte_count register bytes). Each tick yields exactly
// one result beat on m_axis with the SCL level, the SDA pull-low, busy, a read
// byte with its valid flag, the write-byte take strobe, the current byte index
// and done/ok status. The caller presents the next write byte in wr_byte on
// every tick; it is consumed on the tick whose result shows wr_take.
// A new tick is accepted every cycle unless m_axis stalls: the sequencer state
// register is updated in the same cycle the tick is taken, and the single result
// register holds the beat. When m_axis stalls, s_axis_tready drops only while
// the result register is full and not being drained, so no tick is lost or
// duplicated. Timing registers are written over the cfg channel (always ready)
// only while idle, a rule the block does not enforce and the user must keep.
// Reset (rst_n low, asynchronous) returns the bus to released, the sequencer to
// idle, the timing registers to their defaults and empties the result beat.
`default_nettype none

module i2c_master_register_access_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // tdata from bit 0: dev_addr[7:0], reg_addr[15:8], byte_count[24:16],
    // wr_byte[32:25], sda_sample[33], zero pad[39:34]
    input  wire logic [i2cra_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser from bit 0: cmd[1:0]
    input  wire logic [i2cra_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata from bit 0: scl_level[0], sda_pull_low[1], busy_res[2], rd_byte[10:3],
    // rd_valid[11], wr_take[12], byte_index[20:13], done_res[21], ok[22], pad[23]
    output logic [i2cra_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [9:0]                       cfg_data
);
    import i2cra_pkg::*;

    cfg_t      cfg;
    seq_t      st_reg;
    seq_t      st_next;
    tick_in_t  tin;
    tick_out_t res;
    logic      in_acc;
    logic      out_valid_reg;
    tick_out_t out_data_reg;

    assign cfg_ready = 1'b1;

    i2cra_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the input beat
    assign tin.cmd        = s_axis_tuser;
    assign tin.dev_addr   = s_axis_tdata[7:0];
    assign tin.reg_addr   = s_axis_tdata[15:8];
    assign tin.byte_count = s_axis_tdata[24:16];
    assign tin.wr_byte    = s_axis_tdata[32:25];
    assign tin.sda_sample = s_axis_tdata[33];

    i2cra_step u_step (
        .st  (st_reg),
        .tin (tin),
        .cfg (cfg),
        .nxt (st_next),
        .res (res)
    );

    // Accept while the result register is empty or draining
    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    // Advance the sequencer on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= SEQ_RESET;
        end
        else if (in_acc)
        begin
            st_reg <= st_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

    `include "i2c_master_register_access_unit_assert.svh"

    `I2CRA_ASSERT_NEXT(a_done_goes_idle, clk, rst_n, in_acc && res.done_res,
        st_reg.phase == PH_IDLE)
    `I2CRA_ASSERT_NEXT(a_idle_holds, clk, rst_n,
        in_acc && st_reg.phase == PH_IDLE && tin.cmd != CMD_READ && tin.cmd != CMD_WRITE,
        st_reg.phase == PH_IDLE)
    `I2CRA_ASSERT_NOW(a_rd_only_on_read, clk, rst_n, in_acc && res.rd_valid, st_reg.is_read)
    `I2CRA_ASSERT_NOW(a_wr_only_on_write, clk, rst_n, in_acc && res.wr_take, !st_reg.is_read)
    `I2CRA_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid_reg, s_axis_tready)

endmodule

`default_nettype wire

// ===== tb/i2c_master_register_access_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the I2C master register access unit: tracks every accepted tick,
// predicts the line levels and status of its result beat, and compares them.
// Depends on i2cra_pkg for field widths, command and register codes, phases.

module i2c_master_register_access_unit_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [i2cra_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [i2cra_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [i2cra_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [9:0]                       cfg_data,
    output int                               mismatch_count,
    output int                               pending_beats
);
    import i2cra_pkg::*;

    localparam logic [9:0] HIGH_TICKS_RST     = 10'd13;
    localparam logic [9:0] SETUP_TICKS_RST    = 10'd5;
    localparam logic [9:0] LOW_TAIL_TICKS_RST = 10'd8;
    localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd50;

    // Timing registers as last written
    logic [9:0] t_high, t_setup, t_tail;
    logic [7:0] ack_limit;

    // Sequencer copy
    phase_t     bus_phase;
    logic [9:0] hold_left;
    logic [3:0] bit_idx;
    logic [7:0] shreg;
    logic [8:0] bytes_rem;
    logic [7:0] poll_cnt;
    logic [7:0] dev_latch, reg_latch;
    logic       rd_mode, scl_q, sda_q;
    stage_t     seq_stage;
    logic [8:0] data_idx;
    logic       aborted;

    tick_out_t beat;
    tick_out_t exp_beat;
    tick_out_t due_beats[$];
    int        beat_no;

    task automatic move_to(input phase_t ph, input logic scl, input logic sda,
                           input logic [9:0] dur);
        bus_phase = ph;
        scl_q     = scl;
        sda_q     = sda;
        hold_left = dur;
    endtask

    // Begin shifting out shreg, MSB first; SDA is pulled low for a zero bit
    task automatic send_byte();
        bit_idx = 4'd0;
        move_to(PH_TX_SETUP, 1'b0, ~shreg[7], t_setup);
    endtask

    task automatic send_stop();
        move_to(PH_SP_A, 1'b0, 1'b1, t_high);
    endtask

    task automatic recv_byte();
        bit_idx = 4'd0;
        shreg   = 8'd0;
        move_to(PH_RX_LOW, 1'b0, 1'b0, t_high);
    endtask

    // Take the next data byte of a write, or stop when none is left
    task automatic load_write_byte(input logic [7:0] wr);
        if (bytes_rem == 9'd0)
            send_stop();
        else
        begin
            shreg        = wr;
            beat.wr_take = 1'b1;
            seq_stage    = SG_DATA;
            send_byte();
        end
    endtask

    // Decide what follows an acknowledged byte
    task automatic ack_done(input logic [7:0] wr);
        case (seq_stage)
            SG_DEV:
            begin
                shreg     = reg_latch;
                seq_stage = SG_REG;
                send_byte();
            end
            SG_REG:
            begin
                if (rd_mode)
                begin
                    // repeated start, then the read address
                    seq_stage = SG_DEVRD;
                    shreg     = dev_latch + 8'd1;
                    move_to(PH_ST_A, 1'b1, 1'b0, t_high);
                end
                else
                    load_write_byte(wr);
            end
            SG_DEVRD:
            begin
                if (bytes_rem == 9'd0)
                    send_stop();
                else
                    recv_byte();
            end
            default:
            begin
                if (bytes_rem != 9'd0)
                    bytes_rem--;
                data_idx++;
                load_write_byte(wr);
            end
        endcase
    endtask

    // Segment expired: move to the next bus segment
    task automatic advance_phase(input logic [7:0] wr, input logic sda);
        case (bus_phase)
            PH_ST_A:     move_to(PH_ST_B, 1'b1, 1'b1, t_high);
            PH_ST_B:     send_byte();
            PH_TX_SETUP: move_to(PH_TX_HIGH, 1'b1, sda_q, t_high);
            PH_TX_HIGH:  move_to(PH_TX_LOW, 1'b0, sda_q, t_tail);
            PH_TX_LOW:
            begin
                shreg = shreg << 1;
                bit_idx++;
                if (bit_idx >= 4'd8)
                begin
                    poll_cnt = 8'd0;
                    move_to(PH_ACK_REL, 1'b0, 1'b0, t_high);
                end
                else
                    move_to(PH_TX_SETUP, 1'b0, ~shreg[7], t_setup);
            end
            PH_ACK_REL:  move_to(PH_ACK_POLL, 1'b1, 1'b0, 10'd0);
            PH_ACK_HOLD: ack_done(wr);
            PH_RX_LOW:
            begin
                // read bit is taken as SCL rises
                shreg = {shreg[6:0], sda};
                move_to(PH_RX_HIGH, 1'b1, 1'b0, t_high);
            end
            PH_RX_HIGH:
            begin
                bit_idx++;
                if (bit_idx >= 4'd8)
                begin
                    beat.rd_byte  = shreg;
                    beat.rd_valid = 1'b1;
                    // ack all but the last byte, which gets a nack
                    move_to(PH_RA_LOW, 1'b0, bytes_rem > 9'd1, t_high);
                end
                else
                    move_to(PH_RX_LOW, 1'b0, 1'b0, t_high);
            end
            PH_RA_LOW:   move_to(PH_RA_HIGH, 1'b1, sda_q, t_high);
            PH_RA_HIGH:
            begin
                if (bytes_rem != 9'd0)
                    bytes_rem--;
                data_idx++;
                if (bytes_rem == 9'd0)
                    send_stop();
                else
                    recv_byte();
            end
            PH_SP_A:     move_to(PH_SP_B, 1'b1, 1'b0, t_high);
            default:
            begin
                move_to(PH_IDLE, 1'b1, 1'b0, 10'd0);
                beat.done_res = 1'b1;
                beat.ok       = ~aborted;
            end
        endcase
    endtask

    // Step the sequencer by one tick and queue the beat it must produce
    task automatic bus_tick(input logic [1:0] cmd, input logic [7:0] dev,
                            input logic [7:0] reg_a, input logic [8:0] cnt,
                            input logic [7:0] wr, input logic sda);
        beat = '0;
        if (bus_phase == PH_IDLE)
        begin
            if (cmd == CMD_READ || cmd == CMD_WRITE)
            begin
                dev_latch = dev;
                reg_latch = reg_a;
                rd_mode   = (cmd == CMD_READ);
                bytes_rem = (cnt > MAX_BYTES_W) ? MAX_BYTES_W : cnt;
                data_idx  = 9'd0;
                aborted   = 1'b0;
                poll_cnt  = 8'd0;
                seq_stage = SG_DEV;
                shreg     = dev;
                move_to(PH_ST_A, 1'b1, 1'b0, t_high);
            end
        end
        else if (bus_phase == PH_ACK_POLL)
        begin
            if (!sda)
                move_to(PH_ACK_HOLD, 1'b1, 1'b0, t_high);
            else if (poll_cnt >= ack_limit)
            begin
                aborted = 1'b1;
                send_stop();
            end
            else
                poll_cnt++;
        end
        else if (hold_left > 10'd1)
            hold_left--;
        else
            advance_phase(wr, sda);

        beat.scl_level    = scl_q;
        beat.sda_pull_low = sda_q;
        beat.busy_res     = (bus_phase != PH_IDLE);
        beat.byte_index   = (bus_phase != PH_IDLE) ? data_idx[7:0] : 8'd0;
        due_beats.push_back(beat);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            if (mismatch_count < 10)
                $display("beat %0d %s: expected %0h, got %0h", beat_no, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_high         = HIGH_TICKS_RST;
            t_setup        = SETUP_TICKS_RST;
            t_tail         = LOW_TAIL_TICKS_RST;
            ack_limit      = ACK_TIMEOUT_RST;
            bus_phase      = PH_IDLE;
            hold_left      = '0;
            bit_idx        = '0;
            shreg          = '0;
            bytes_rem      = '0;
            poll_cnt       = '0;
            dev_latch      = '0;
            reg_latch      = '0;
            rd_mode        = 1'b0;
            scl_q          = 1'b1;
            sda_q          = 1'b0;
            seq_stage      = SG_DEV;
            data_idx       = '0;
            aborted        = 1'b0;
            beat_no        = 0;
            mismatch_count = 0;
            due_beats.delete();
        end
        else
        begin
            // compare a result beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_beats.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("beat %0d: result %0h with no tick pending",
                                 beat_no, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    exp_beat = due_beats.pop_front();
                    check_field("scl_level", exp_beat.scl_level, m_axis_tdata[0]);
                    check_field("sda_pull_low", exp_beat.sda_pull_low, m_axis_tdata[1]);
                    check_field("busy", exp_beat.busy_res, m_axis_tdata[2]);
                    check_field("rd_byte", exp_beat.rd_byte, m_axis_tdata[10:3]);
                    check_field("rd_valid", exp_beat.rd_valid, m_axis_tdata[11]);
                    check_field("wr_take", exp_beat.wr_take, m_axis_tdata[12]);
                    check_field("byte_index", exp_beat.byte_index, m_axis_tdata[20:13]);
                    check_field("done", exp_beat.done_res, m_axis_tdata[21]);
                    check_field("ok", exp_beat.ok, m_axis_tdata[22]);
                end
                beat_no++;
            end

            // track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HIGH_TICKS:     t_high    = cfg_data;
                    CFG_SETUP_TICKS:    t_setup   = cfg_data;
                    CFG_LOW_TAIL_TICKS: t_tail    = cfg_data;
                    CFG_ACK_TIMEOUT:    ack_limit = cfg_data[7:0];
                    default:            ;
                endcase
            end

            // predict the beat of each accepted tick
            if (s_axis_tvalid && s_axis_tready)
                bus_tick(s_axis_tuser[1:0], s_axis_tdata[7:0], s_axis_tdata[15:8],
                         s_axis_tdata[24:16], s_axis_tdata[32:25], s_axis_tdata[33]);
        end
        pending_beats = due_beats.size();
    end

endmodule

// ===== tb/i2c_master_register_access_unit_tb.sv =====
`timescale 1ns / 1ps
// Top of the I2C master register access unit testbench: clock, reset, tick
// stimulus, result sink with stalls, timing register phases and the verdict.
// Depends on i2cra_pkg, the unit itself and i2c_master_register_access_unit_checker.

module i2c_master_register_access_unit_tb;
    import i2cra_pkg::*;

    localparam int         CYCLE_LIMIT  = 20_000;
    localparam int         HOLD_CYCLES  = 300;
    localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
    localparam int         BUSY_BIT     = 2;
    localparam int         RD_VALID_BIT = 11;
    localparam int         WR_TAKE_BIT  = 12;
    localparam int         DONE_BIT     = 21;
    localparam int         OK_BIT       = 22;

    typedef enum logic [1:0] {
        SDA_COIN,
        SDA_MOSTLY_LOW,
        SDA_STUCK_HIGH
    } sda_mode_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index     = '0;
    logic [9:0]            cfg_data      = '0;

    int mismatch_count;
    int pending_beats;

    sda_mode_t sda_mode       = SDA_COIN;
    bit        no_idle        = 1'b0;
    int        sent_cnt       = 0;
    int        recv_cnt       = 0;
    int        last_cmd_beat  = 0;
    int        last_idle_beat = 0;
    int        xfer_ok        = 0;
    int        xfer_abort     = 0;
    int        rd_seen        = 0;
    int        wr_seen        = 0;
    int        stall_left     = 0;
    int        next_hold_at   = 100;
    int        cycle_cnt      = 0;

    i2c_master_register_access_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    i2c_master_register_access_unit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Level the emulated device puts on SDA this tick
    function automatic logic line_sample();
        case (sda_mode)
            SDA_STUCK_HIGH: return 1'b1;
            SDA_MOSTLY_LOW: return ($urandom_range(0, 9) == 0);
            default:        return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Offer one tick beat, with random gaps, and hold it until accepted
    task automatic send_tick(input logic [1:0] cmd, input logic [7:0] dev,
                             input logic [7:0] reg_a, input logic [8:0] cnt);
        logic [7:0] wr;
        wr = 8'($urandom_range(0, 255));
        while (!no_idle && $urandom_range(0, 99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        if (cmd == CMD_READ || cmd == CMD_WRITE)
            last_cmd_beat = sent_cnt + 1;
        s_axis_tdata  <= {{(IN_DATA_W - 34){1'b0}}, line_sample(), wr, cnt, reg_a, dev};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sent_cnt++;
    endtask

    task automatic start_transfer(input logic [1:0] cmd, input logic [7:0] dev,
                                  input logic [7:0] reg_a, input logic [8:0] cnt,
                                  input sda_mode_t mode);
        sda_mode = mode;
        send_tick(cmd, dev, reg_a, cnt);
    endtask

    // Keep ticking until a result after the last command shows idle, then drain
    task automatic settle();
        while (last_idle_beat <= last_cmd_beat)
            send_tick(CMD_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      9'($urandom_range(0, 511)));
        s_axis_tvalid <= 1'b0;
        while (recv_cnt != sent_cnt || pending_beats != 0)
            @(posedge clk);
    endtask

    // Write all four timing registers; the unit is idle here
    task automatic set_timing(input logic [9:0] high, input logic [9:0] setup,
                              input logic [9:0] tail, input logic [9:0] ack);
        logic [9:0] vals [4];
        logic [1:0] idx [4];
        int         i;
        vals = '{high, setup, tail, ack};
        idx  = '{CFG_HIGH_TICKS, CFG_SETUP_TICKS, CFG_LOW_TAIL_TICKS, CFG_ACK_TIMEOUT};
        for (i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random ticks: mostly plain ticks, some transfer starts, a few unknown commands
    task automatic run_random(input int n);
        int         k;
        int         roll;
        logic [1:0] cmd;
        logic [8:0] cnt;
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                cmd = (roll < 4) ? CMD_READ : CMD_WRITE;
                cnt = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(4, 8))
                                                   : 9'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0:       sda_mode = SDA_STUCK_HIGH;
                    1:       sda_mode = SDA_MOSTLY_LOW;
                    default: sda_mode = SDA_COIN;
                endcase
            end
            else
            begin
                cmd = (roll < 10) ? CMD_UNKNOWN : CMD_NONE;
                cnt = 9'($urandom_range(0, 511));
            end
            send_tick(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cnt);
        end
        settle();
    endtask

    // Result sink: count beats, stall at random, and hold off now and then
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                recv_cnt++;
                if (!m_axis_tdata[BUSY_BIT])
                    last_idle_beat = recv_cnt;
                if (m_axis_tdata[DONE_BIT])
                begin
                    if (m_axis_tdata[OK_BIT])
                        xfer_ok++;
                    else
                        xfer_abort++;
                end
                if (m_axis_tdata[RD_VALID_BIT])
                    rd_seen++;
                if (m_axis_tdata[WR_TAKE_BIT])
                    wr_seen++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_cnt >= next_hold_at)
            begin
                stall_left = HOLD_CYCLES - 1;
                next_hold_at += 20000;
                m_axis_tready <= 1'b0;
            end
            else if (no_idle)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 33);
        end
    end

    // Cycle limit
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: no ack ever arrives, so the write aborts with stop
        start_transfer(CMD_WRITE, 8'h42, 8'h24, 9'd1, SDA_STUCK_HIGH);
        settle();

        // Zero durations act as one tick; zero ack timeout; no idling here
        set_timing(10'd0, 10'd0, 10'd0, 10'd0);
        no_idle = 1'b1;
        // read of device 0xff wraps the read address to zero
        start_transfer(CMD_READ, 8'hFF, 8'h5A, 9'd1, SDA_MOSTLY_LOW);
        // a second command while busy is dropped
        send_tick(CMD_WRITE, 8'h3C, 8'hC3, 9'd1);
        send_tick(CMD_UNKNOWN, 8'hFF, 8'hFF, 9'h1FF);
        settle();
        no_idle = 1'b0;

        // Short segments with random transfers; ack field takes the low byte
        set_timing(10'd1, 10'd2, 10'd1, 10'd258);
        run_random(50);

        // Drain and let the last beat settle
        while (pending_beats != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d ticks: %0d transfers completed, %0d aborted without ack",
                 sent_cnt, xfer_ok, xfer_abort);
        $display("%0d bytes read, %0d write bytes taken, %0d mismatches",
                 rd_seen, wr_seen, mismatch_count);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/i2cra_pkg.sv
sv/i2cra_cfg.sv
sv/i2cra_step.sv
sv/i2c_master_register_access_unit.sv
tb/i2c_master_register_access_unit_checker.sv
tb/i2c_master_register_access_unit_tb.sv
